### rtl/core/gpsr_pkg.sv
// ----------------------------------------------------------------------------
// gpsr_pkg
// Shared widths, register indexes, cell tags and the count clamp helper for the grid path
// sum range check.
// ----------------------------------------------------------------------------
package gpsr_pkg;

    // Field and sum widths.
    localparam int CELL_W    = 16;
    localparam int SUM_W     = 32;
    localparam int CNT_REG_W = 11;
    localparam int CFG_IDX_W = 8;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 72;

    // Default grid limits.
    localparam int DEF_MAX_ROWS = 1024;
    localparam int DEF_MAX_COLS = 1024;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT = 8'd0,
        REG_COL_COUNT = 8'd1
    } cfg_reg_t;

    // Position tags that travel with a cell into the sum stage.
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_cell;
    } cell_tag_t;

    // A count of zero acts as one, a count above the limit acts as the limit.
    function automatic int clamp_count(input logic [CNT_REG_W-1:0] raw, input int limit);
        int value;
        value = int'(raw);
        if (value == 0)
        begin
            return 1;
        end
        if (value > limit)
        begin
            return limit;
        end
        return value;
    endfunction

endpackage

### rtl/core/gpsr_row_mem.sv
// ----------------------------------------------------------------------------
// gpsr_row_mem
// Row buffer for the upper path sums: one write port, one registered read
// port, with the same-cycle write passed through to the read data.
// ----------------------------------------------------------------------------
module gpsr_row_mem #(
    parameter int DEPTH = gpsr_pkg::DEF_MAX_COLS,
    parameter int AW    = 10,
    parameter int DW    = 2 * gpsr_pkg::SUM_W
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; a write to the same entry in this cycle wins.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/gpsr_front.sv
// ----------------------------------------------------------------------------
// gpsr_front
// Configuration registers, grid position tracking and the input register.
// Issues the row buffer read for each accepted cell.
// ----------------------------------------------------------------------------
module gpsr_front #(
    parameter int MAX_ROWS = gpsr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gpsr_pkg::DEF_MAX_COLS,
    parameter int COL_AW   = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gpsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gpsr_pkg::CNT_REG_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gpsr_pkg::CELL_W-1:0]       cell_value,
    input  logic                              stg_advance,
    output logic                              stg_valid,
    output logic [gpsr_pkg::CELL_W-1:0]       stg_value,
    output gpsr_pkg::cell_tag_t               stg_tag,
    output logic [COL_AW-1:0]                 stg_col,
    output logic                              rd_en,
    output logic [COL_AW-1:0]                 rd_addr,
    output logic                              length_even
);

    localparam int ROW_CW = $clog2(MAX_ROWS + 1);
    localparam int COL_CW = $clog2(MAX_COLS + 1);

    logic [ROW_CW-1:0] row_eff_reg, row_eff_next;
    logic [COL_CW-1:0] col_eff_reg, col_eff_next;
    logic              even_reg, even_next;
    logic [ROW_CW-1:0] row_pos_reg, row_pos_next;
    logic [COL_CW-1:0] col_pos_reg, col_pos_next;

    logic                      stg_valid_reg;
    logic [gpsr_pkg::CELL_W-1:0] stg_value_reg;
    gpsr_pkg::cell_tag_t       stg_tag_reg;
    logic [COL_AW-1:0]         stg_col_reg;

    logic                accept;
    logic                cfg_write;
    logic                col_last;
    logic                row_last;
    gpsr_pkg::cell_tag_t tag_now;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;
    assign s_tready  = !stg_valid_reg || stg_advance;
    assign accept    = s_tvalid && s_tready;

    assign col_last = (col_pos_reg == (col_eff_reg - 1'b1));
    assign row_last = (row_pos_reg == (row_eff_reg - 1'b1));

    always_comb
    begin
        tag_now.first_row = (row_pos_reg == '0);
        tag_now.first_col = (col_pos_reg == '0);
        tag_now.last_cell = col_last && row_last;
    end

    // Clamped grid size and path length parity, updated on register writes.
    always_comb
    begin
        row_eff_next = row_eff_reg;
        col_eff_next = col_eff_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                gpsr_pkg::REG_ROW_COUNT:
                begin
                    row_eff_next = ROW_CW'(gpsr_pkg::clamp_count(cfg_data, MAX_ROWS));
                end
                gpsr_pkg::REG_COL_COUNT:
                begin
                    col_eff_next = COL_CW'(gpsr_pkg::clamp_count(cfg_data, MAX_COLS));
                end
                default:
                begin
                    row_eff_next = row_eff_reg;
                end
            endcase
        end
        // Rows plus columns minus one is even when the two counts differ in parity.
        even_next = row_eff_next[0] ^ col_eff_next[0];
    end

    // Position of the next cell; any register write restarts the grid.
    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (cfg_write)
        begin
            row_pos_next = '0;
            col_pos_next = '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_pos_next = '0;
                row_pos_next = row_last ? '0 : (row_pos_reg + 1'b1);
            end
            else
            begin
                col_pos_next = col_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_eff_reg   <= ROW_CW'(1);
            col_eff_reg   <= COL_CW'(1);
            even_reg      <= 1'b0;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            row_eff_reg <= row_eff_next;
            col_eff_reg <= col_eff_next;
            even_reg    <= even_next;
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            if (accept)
            begin
                stg_valid_reg <= 1'b1;
            end
            else if (stg_advance)
            begin
                stg_valid_reg <= 1'b0;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_value_reg <= cell_value;
            stg_tag_reg   <= tag_now;
            stg_col_reg   <= col_pos_reg[COL_AW-1:0];
        end
    end

    assign rd_en       = accept;
    assign rd_addr     = col_pos_reg[COL_AW-1:0];
    assign stg_valid   = stg_valid_reg;
    assign stg_value   = stg_value_reg;
    assign stg_tag     = stg_tag_reg;
    assign stg_col     = stg_col_reg;
    assign length_even = even_reg;

    // The tracked position always lies inside the configured grid.
    a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        col_pos_reg < col_eff_reg)
        else $error("column position outside the grid");

    a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        row_pos_reg < row_eff_reg)
        else $error("row position outside the grid");

endmodule

### rtl/core/gpsr_sum_stage.sv
// ----------------------------------------------------------------------------
// gpsr_sum_stage
// One add and compare per sum: combines the upper and left path sums with the
// cell value, keeps the left neighbour, and holds the result register.
// ----------------------------------------------------------------------------
module gpsr_sum_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            stg_valid,
    input  logic [gpsr_pkg::CELL_W-1:0]     stg_value,
    input  gpsr_pkg::cell_tag_t             stg_tag,
    input  logic [2*gpsr_pkg::SUM_W-1:0]    upper_data,
    input  logic                            length_even,
    output logic                            stg_advance,
    output logic [2*gpsr_pkg::SUM_W-1:0]    wr_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gpsr_pkg::OUT_W-1:0]      m_tdata
);

    localparam int SW = gpsr_pkg::SUM_W;

    logic signed [SW-1:0] left_max_reg, left_min_reg;
    logic signed [SW-1:0] up_max, up_min;
    logic signed [SW-1:0] base_max, base_min;
    logic signed [SW-1:0] cell_ext;
    logic signed [SW-1:0] sum_max, sum_min;

    logic                 out_valid_reg;
    logic signed [SW-1:0] out_max_reg, out_min_reg;
    logic                 out_even_reg;
    logic                 out_zero_reg;
    logic                 zero_next;
    logic                 load_out;

    assign up_max   = upper_data[SW-1:0];
    assign up_min   = upper_data[2*SW-1:SW];
    assign cell_ext = {{(SW - gpsr_pkg::CELL_W){stg_value[gpsr_pkg::CELL_W-1]}}, stg_value};

    // Pick the best predecessor for each sum.
    always_comb
    begin
        if (stg_tag.first_row && stg_tag.first_col)
        begin
            base_max = '0;
            base_min = '0;
        end
        else if (stg_tag.first_row)
        begin
            base_max = left_max_reg;
            base_min = left_min_reg;
        end
        else if (stg_tag.first_col)
        begin
            base_max = up_max;
            base_min = up_min;
        end
        else
        begin
            base_max = (up_max > left_max_reg) ? up_max : left_max_reg;
            base_min = (up_min < left_min_reg) ? up_min : left_min_reg;
        end
        sum_max = base_max + cell_ext;
        sum_min = base_min + cell_ext;
    end

    // A cell moves on unless it is the last one and the result is still waiting.
    assign stg_advance = stg_valid && (!stg_tag.last_cell || !out_valid_reg || m_tready);
    assign load_out    = stg_advance && stg_tag.last_cell;
    assign wr_data     = {sum_min, sum_max};
    assign zero_next   = length_even && ((sum_min[SW-1]) || (sum_min == '0)) && !sum_max[SW-1];

    // Left neighbour sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_max_reg <= '0;
            left_min_reg <= '0;
        end
        else if (stg_advance)
        begin
            left_max_reg <= sum_max;
            left_min_reg <= sum_min;
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_max_reg  <= sum_max;
            out_min_reg  <= sum_min;
            out_even_reg <= length_even;
            out_zero_reg <= zero_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(gpsr_pkg::OUT_W - 2*SW - 2){1'b0}},
                       out_zero_reg, out_even_reg, out_min_reg, out_max_reg};

    // The maximum path sum never lies below the minimum.
    a_max_ge_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_max_reg >= out_min_reg))
        else $error("maximum path sum below minimum");

    // A zero-sum verdict needs an even path length.
    a_zero_even: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_zero_reg) |-> out_even_reg)
        else $error("zero-sum verdict with odd path length");

    // A new result comes only from the last cell of a grid.
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(stg_valid && stg_tag.last_cell))
        else $error("result loaded from a cell that is not the last");

endmodule

### rtl/core/grid_path_sum_range_check.sv
// ----------------------------------------------------------------------------
// grid_path_sum_range_check
// Largest and smallest right/down path sums over a streamed grid.
// ----------------------------------------------------------------------------
// Cells arrive on the s_ channel in row-major order, one request per cell.
// The cfg channel writes row_count (index 0) and col_count (index 1); any
// write, to any index, restarts the grid at the top-left cell. A count of
// zero acts as one, a count above the limit acts as the limit. Write
// configuration only while no cell is in flight.
// After the last cell of a grid one result request appears on the m_ channel
// with both path sums, the path length parity and the zero-sum verdict.
// The last cell is registered in the input register, and its sums are
// registered in the result register, which drives the m_ channel.
// Throughput: one cell per cycle, set by the add and compare loop on the
// left neighbour sums and the single read port of the row buffer.
// When the receiver stalls, the result waits in the output register while
// further cells keep streaming; only the last cell of the next grid waits.
// Reset sets both counts to one and the position to the top-left cell; the
// row buffer is not cleared, since each entry is written before its read data is used.
// ----------------------------------------------------------------------------
module grid_path_sum_range_check #(
    parameter int MAX_ROWS = gpsr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gpsr_pkg::DEF_MAX_COLS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gpsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gpsr_pkg::CNT_REG_W-1:0] cfg_data,
    // Cell input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gpsr_pkg::IN_W-1:0]      s_tdata,  // [15:0] cell_value
    // Result output stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gpsr_pkg::OUT_W-1:0]     m_tdata   // [31:0] max_sum, [63:32] min_sum,
                                                     // [64] length_even, [65] zero_possible
);

    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_DW = 2 * gpsr_pkg::SUM_W;

    logic                        stg_advance;
    logic                        stg_valid;
    logic [gpsr_pkg::CELL_W-1:0] stg_value;
    gpsr_pkg::cell_tag_t         stg_tag;
    logic [COL_AW-1:0]           stg_col;
    logic                        rd_en;
    logic [COL_AW-1:0]           rd_addr;
    logic [ROW_DW-1:0]           rd_data;
    logic [ROW_DW-1:0]           wr_data;
    logic                        length_even;

    // Configuration, position tracking and input register.
    gpsr_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .COL_AW   (COL_AW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .cell_value  (s_tdata[gpsr_pkg::CELL_W-1:0]),
        .stg_advance (stg_advance),
        .stg_valid   (stg_valid),
        .stg_value   (stg_value),
        .stg_tag     (stg_tag),
        .stg_col     (stg_col),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .length_even (length_even)
    );

    // Upper row of maximum and minimum sums.
    gpsr_row_mem #(
        .DEPTH (MAX_COLS),
        .AW    (COL_AW),
        .DW    (ROW_DW)
    ) u_row_mem (
        .clk     (clk),
        .wr_en   (stg_advance),
        .wr_addr (stg_col),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Path sum update and result register.
    gpsr_sum_stage u_sum_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .stg_valid   (stg_valid),
        .stg_value   (stg_value),
        .stg_tag     (stg_tag),
        .upper_data  (rd_data),
        .length_even (length_even),
        .stg_advance (stg_advance),
        .wr_data     (wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

### sim/tb_grid_path_sum_range_check.sv
// ----------------------------------------------------------------------------
// tb_grid_path_sum_range_check
// Self-checking testbench for the grid path sum range check.
// ----------------------------------------------------------------------------
// Grids of signed cells are streamed into the block, and the row and column
// counts are changed between phases. Every accepted cell feeds a local
// recurrence of the largest and smallest right/down path sums. Each result
// request is compared field by field with the oldest expected result.
// The sender works in bursts and the receiver stalls on its own pattern.
// A short directed part covers value extremes, odd and even path lengths,
// zero and oversized counts, a grid cut short by a register write and a write
// to an unknown index. Random phases of mostly small grids follow.
// ----------------------------------------------------------------------------
module tb_grid_path_sum_range_check;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELL_W    = gpsr_pkg::CELL_W;
    localparam int SUM_W     = gpsr_pkg::SUM_W;
    localparam int CNT_REG_W = gpsr_pkg::CNT_REG_W;
    localparam int CFG_IDX_W = gpsr_pkg::CFG_IDX_W;
    localparam int IN_W      = gpsr_pkg::IN_W;
    localparam int OUT_W     = gpsr_pkg::OUT_W;

    localparam int GRID_ROWS_LIMIT = gpsr_pkg::DEF_MAX_ROWS;
    localparam int GRID_COLS_LIMIT = gpsr_pkg::DEF_MAX_COLS;
    localparam int RANDOM_CELLS    = 720;
    localparam int LONG_LINE_CELLS = 40;
    localparam int SETTLE_CYCLES   = 6;

    // How the values of a run of cells are chosen.
    typedef enum int {
        FILL_WIDE,
        FILL_NARROW,
        FILL_EXTREME,
        FILL_TOP,
        FILL_BOTTOM
    } cell_fill_t;

    // One expected result request.
    typedef struct {
        logic signed [SUM_W-1:0] max_sum;
        logic signed [SUM_W-1:0] min_sum;
        logic                    length_even;
        logic                    zero_possible;
    } path_result_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_REG_W-1:0] cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata   = '0;   // [15:0] cell_value
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;          // [31:0] max_sum, [63:32] min_sum,
                                            // [64] length_even, [65] zero_possible

    // Stimulus bookkeeping.
    logic [CELL_W-1:0] pending_cells[$];
    path_result_t      expected_paths[$];
    int                cells_pushed = 0;
    int                cells_taken  = 0;
    int                error_count  = 0;

    // Local copy of the block's registers and running sums.
    logic [CNT_REG_W-1:0]    rows_reg = 11'd1;
    logic [CNT_REG_W-1:0]    cols_reg = 11'd1;
    logic signed [SUM_W-1:0] upper_max[GRID_COLS_LIMIT];
    logic signed [SUM_W-1:0] upper_min[GRID_COLS_LIMIT];
    logic signed [SUM_W-1:0] left_max = '0;
    logic signed [SUM_W-1:0] left_min = '0;
    int                      row_pos  = 0;
    int                      col_pos  = 0;

    // Sender and receiver pacing.
    int burst_left  = 0;
    int gap_left    = 0;
    int hold_left   = 0;
    int pace_cycles = 0;
    bit steady_sink = 1'b0;

    grid_path_sum_range_check uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // A count of zero behaves as one, an oversized count as the limit.
    function automatic int effective_count(input logic [CNT_REG_W-1:0] raw, input int limit);
        int value;
        value = int'(raw);
        if (value == 0)
        begin
            value = 1;
        end
        else if (value > limit)
        begin
            value = limit;
        end
        return value;
    endfunction

    function automatic logic [CELL_W-1:0] random_cell(input cell_fill_t fill);
        logic [CELL_W-1:0] value;
        case (fill)
            FILL_WIDE:    value = CELL_W'($urandom);
            FILL_NARROW:  value = CELL_W'(int'($urandom_range(0, 6)) - 3);
            FILL_EXTREME: value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            FILL_TOP:     value = 16'h7FFF;
            default:      value = 16'h8000;
        endcase
        return value;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic push_cell(input logic [CELL_W-1:0] value);
        pending_cells.push_back(value);
        cells_pushed++;
    endtask

    task automatic push_cells(input int count, input cell_fill_t fill);
        for (int i = 0; i < count; i++)
        begin
            push_cell(random_cell(fill));
        end
    endtask

    // One register write request, held until the block takes it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CNT_REG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every cell is taken and every result has arrived, then let
    // any cell that produces no result drain through the pipeline.
    task automatic wait_idle();
        while (cells_taken != cells_pushed || expected_paths.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Cell driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_cells.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_cells.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: alternating ready and stall stretches, with windows
    // in which it never stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            hold_left   = 0;
            pace_cycles = 0;
            steady_sink = 1'b0;
        end
        else
        begin
            pace_cycles++;
            if (pace_cycles % 128 == 0)
            begin
                steady_sink = ($urandom_range(0, 3) == 0);
            end
            if (steady_sink)
            begin
                m_tready <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left--;
            end
            else if (m_tready)
            begin
                m_tready  <= 1'b0;
                hold_left = $urandom_range(0, 24);
            end
            else
            begin
                m_tready  <= 1'b1;
                hold_left = $urandom_range(0, 12);
            end
        end
    end

    // Monitor: checks result requests, tracks register writes and runs the
    // path sum recurrence on every accepted cell.
    always @(posedge clk)
    begin : monitor
        path_result_t            want;
        logic signed [SUM_W-1:0] cell_ext;
        logic signed [SUM_W-1:0] new_max;
        logic signed [SUM_W-1:0] new_min;
        int                      rows_eff;
        int                      cols_eff;
        if (rst_n)
        begin
            // Result check against the oldest expectation.
            if (m_tvalid && m_tready)
            begin
                if (expected_paths.size() == 0)
                begin
                    report_mismatch($sformatf("result with none expected, data %h", m_tdata));
                end
                else
                begin
                    want = expected_paths.pop_front();
                    if (m_tdata[31:0] !== want.max_sum)
                    begin
                        report_mismatch($sformatf("max_sum got %0d expected %0d",
                                        $signed(m_tdata[31:0]), want.max_sum));
                    end
                    if (m_tdata[63:32] !== want.min_sum)
                    begin
                        report_mismatch($sformatf("min_sum got %0d expected %0d",
                                        $signed(m_tdata[63:32]), want.min_sum));
                    end
                    if (m_tdata[64] !== want.length_even)
                    begin
                        report_mismatch($sformatf("length_even got %b expected %b",
                                        m_tdata[64], want.length_even));
                    end
                    if (m_tdata[65] !== want.zero_possible)
                    begin
                        report_mismatch($sformatf("zero_possible got %b expected %b",
                                        m_tdata[65], want.zero_possible));
                    end
                end
            end

            // Any write restarts the grid; only the two known indexes store.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == gpsr_pkg::REG_ROW_COUNT)
                begin
                    rows_reg = cfg_data;
                end
                else if (cfg_index == gpsr_pkg::REG_COL_COUNT)
                begin
                    cols_reg = cfg_data;
                end
                row_pos  = 0;
                col_pos  = 0;
                left_max = '0;
                left_min = '0;
            end

            // Path sum recurrence for one cell.
            if (s_tvalid && s_tready)
            begin
                cells_taken++;
                rows_eff = effective_count(rows_reg, GRID_ROWS_LIMIT);
                cols_eff = effective_count(cols_reg, GRID_COLS_LIMIT);
                cell_ext = {{(SUM_W-CELL_W){s_tdata[CELL_W-1]}}, s_tdata};
                if (col_pos >= cols_eff || row_pos >= rows_eff)
                begin
                    row_pos  = 0;
                    col_pos  = 0;
                    left_max = '0;
                    left_min = '0;
                end
                if (row_pos == 0 && col_pos == 0)
                begin
                    new_max = cell_ext;
                    new_min = cell_ext;
                end
                else if (row_pos == 0)
                begin
                    new_max = left_max + cell_ext;
                    new_min = left_min + cell_ext;
                end
                else if (col_pos == 0)
                begin
                    new_max = upper_max[col_pos] + cell_ext;
                    new_min = upper_min[col_pos] + cell_ext;
                end
                else
                begin
                    new_max = ((upper_max[col_pos] > left_max) ? upper_max[col_pos] : left_max)
                              + cell_ext;
                    new_min = ((upper_min[col_pos] < left_min) ? upper_min[col_pos] : left_min)
                              + cell_ext;
                end
                upper_max[col_pos] = new_max;
                upper_min[col_pos] = new_min;
                left_max = new_max;
                left_min = new_min;

                // Advance the position; the last cell closes the grid.
                if (col_pos + 1 < cols_eff)
                begin
                    col_pos++;
                end
                else
                begin
                    col_pos = 0;
                    if (row_pos + 1 < rows_eff)
                    begin
                        row_pos++;
                    end
                    else
                    begin
                        want.max_sum       = new_max;
                        want.min_sum       = new_min;
                        want.length_even   = ((rows_eff + cols_eff - 1) % 2 == 0);
                        want.zero_possible = want.length_even && new_min <= 0 && new_max >= 0;
                        expected_paths.push_back(want);
                        row_pos  = 0;
                        left_max = '0;
                        left_min = '0;
                    end
                end
            end
        end
    end

    // Stimulus sequence and end of run.
    initial
    begin : stimulus
        logic [CNT_REG_W-1:0] rows_set;
        logic [CNT_REG_W-1:0] cols_set;
        int                   random_cells;
        int                   grid_cells;
        int                   pick;
        cell_fill_t           fill;

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset counts give a single-cell grid with an odd path length.
        push_cell(16'h7FFF);
        push_cell(16'h8000);
        push_cell(16'h0000);
        wait_idle();

        // One row of two cells: even length, a path summing to zero.
        write_reg(gpsr_pkg::REG_COL_COUNT, 11'd2);
        push_cell(16'd5);
        push_cell(-16'sd5);
        push_cell(16'h8000);
        push_cell(16'h8000);
        wait_idle();

        // Two by two: the two paths differ.
        write_reg(gpsr_pkg::REG_ROW_COUNT, 11'd2);
        push_cell(16'd1);
        push_cell(16'd2);
        push_cell(16'd3);
        push_cell(16'd4);
        wait_idle();

        // Zero counts behave as one.
        write_reg(gpsr_pkg::REG_ROW_COUNT, 11'd0);
        write_reg(gpsr_pkg::REG_COL_COUNT, 11'd0);
        push_cell(16'hFFFF);
        wait_idle();

        // Two by three with mixed signs, even length.
        write_reg(gpsr_pkg::REG_ROW_COUNT, 11'd2);
        write_reg(gpsr_pkg::REG_COL_COUNT, 11'd3);
        push_cell(16'd3);
        push_cell(-16'sd1);
        push_cell(16'd2);
        push_cell(-16'sd4);
        push_cell(16'd5);
        push_cell(-16'sd2);
        wait_idle();

        // A grid cut short by a write to an unknown index, then a full grid.
        write_reg(gpsr_pkg::REG_ROW_COUNT, 11'd3);
        write_reg(gpsr_pkg::REG_COL_COUNT, 11'd3);
        push_cells(4, FILL_WIDE);
        wait_idle();
        write_reg(8'hFF, 11'h7FF);
        push_cells(9, FILL_NARROW);
        wait_idle();

        // Oversized counts act as the limit: long tall and wide lines that
        // must not close early, abandoned by the next writes.
        write_reg(gpsr_pkg::REG_ROW_COUNT, 11'h7FF);
        write_reg(gpsr_pkg::REG_COL_COUNT, 11'd1);
        push_cells(LONG_LINE_CELLS, FILL_TOP);
        wait_idle();
        write_reg(gpsr_pkg::REG_ROW_COUNT, 11'd1);
        write_reg(gpsr_pkg::REG_COL_COUNT, 11'd1025);
        push_cells(LONG_LINE_CELLS, FILL_BOTTOM);
        wait_idle();

        // Random phases of mostly small grids.
        random_cells = 0;
        while (random_cells < RANDOM_CELLS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                rows_set = 11'd0;
                cols_set = CNT_REG_W'($urandom_range(0, 6));
            end
            else if (pick == 1)
            begin
                rows_set = CNT_REG_W'($urandom_range(1, 6));
                cols_set = 11'd0;
            end
            else if (pick == 2)
            begin
                rows_set = 11'd1;
                cols_set = CNT_REG_W'($urandom_range(1, 40));
            end
            else if (pick == 3)
            begin
                rows_set = CNT_REG_W'($urandom_range(1, 40));
                cols_set = 11'd1;
            end
            else
            begin
                rows_set = CNT_REG_W'($urandom_range(1, 6));
                cols_set = CNT_REG_W'($urandom_range(1, 6));
            end

            // Both counts in random order, sometimes a write to an unknown index.
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(gpsr_pkg::REG_ROW_COUNT, rows_set);
                write_reg(gpsr_pkg::REG_COL_COUNT, cols_set);
            end
            else
            begin
                write_reg(gpsr_pkg::REG_COL_COUNT, cols_set);
                write_reg(gpsr_pkg::REG_ROW_COUNT, rows_set);
            end
            if ($urandom_range(0, 5) == 0)
            begin
                write_reg(CFG_IDX_W'($urandom_range(2, 255)), CNT_REG_W'($urandom));
            end

            grid_cells = effective_count(rows_set, GRID_ROWS_LIMIT)
                       * effective_count(cols_set, GRID_COLS_LIMIT);
            repeat ($urandom_range(1, 4))
            begin
                fill = cell_fill_t'($urandom_range(FILL_WIDE, FILL_EXTREME));
                push_cells(grid_cells, fill);
                random_cells += grid_cells;
            end

            // An unfinished grid that the next phase's writes abandon.
            if (grid_cells > 1 && $urandom_range(0, 3) == 0)
            begin
                pick = $urandom_range(1, grid_cells - 1);
                push_cells(pick, FILL_WIDE);
                random_cells += pick;
            end
            wait_idle();
        end

        // Drain and decide.
        wait_idle();
        repeat (10) @(posedge clk);
        if (expected_paths.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", expected_paths.size()));
        end
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### grid_path_sum_range_check.f
rtl/core/gpsr_pkg.sv
rtl/core/gpsr_row_mem.sv
rtl/core/gpsr_front.sv
rtl/core/gpsr_sum_stage.sv
rtl/core/grid_path_sum_range_check.sv
sim/tb_grid_path_sum_range_check.sv
